FILE: rtl/rpbu_pkg.sv
// Package for the raw pixel bit unpacker: field widths, register indexes,
// reset values and the result entry type. No dependencies.
package rpbu_pkg;

   localparam int WordBits     = 16;
   localparam int MaxBitDepth  = 16;
   localparam int MinBitDepth  = 8;
   localparam int DepthBits    = 5;
   localparam int CountBits    = 24;
   localparam int HeldBits     = 4;                    // at most 15 leftover bits
   localparam int KeepBits     = (1 << HeldBits) - 1;  // width of the leftover buffer
   localparam int JoinBits     = KeepBits + WordBits;  // leftover bits plus a new word
   localparam int TotalBits    = 5;                    // holds up to 31
   localparam int QueueDepth   = 4;
   localparam int QueueIdxBits = 2;
   localparam int QueueCntBits = 3;
   localparam int CsrIdxBits   = 2;
   localparam int CsrDataBits  = 24;

   localparam logic [CsrIdxBits-1:0] RegBitDepth      = 2'd0;
   localparam logic [CsrIdxBits-1:0] RegPixelsPerFrame = 2'd1;
   localparam logic [CsrIdxBits-1:0] RegFullScaleMode  = 2'd2;

   localparam logic [DepthBits-1:0] BitDepthReset       = 5'd14;
   localparam logic [CountBits-1:0] PixelsPerFrameReset = 24'd2073600;

   typedef struct packed {
      logic [WordBits-1:0] pixel_value;
      logic                frame_end;
   } result_type;

endpackage

FILE: rtl/raw_pixel_bit_unpacker.sv
// Raw pixel bit unpacker top level: input register, unpack logic and a
// four-entry result queue. Depends on rpbu_pkg.
//
// A word passes from the input register into the result queue, whose head
// the rsp port shows. Throughput: one word per cycle while each word yields
// at most one pixel and rsp_stall is low; words that yield two pixels fill
// the queue faster than the single result port drains it and stall the input.
// Reset (synchronous, active high) empties the queue, clears the bit buffer
// and pixel counter, and loads the register reset values.
module raw_pixel_bit_unpacker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [rpbu_pkg::WordBits-1:0]       req_packed_word,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [rpbu_pkg::WordBits-1:0]       rsp_pixel_value,
   output logic                                rsp_frame_end,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rpbu_pkg::CsrIdxBits-1:0]     csr_index,
   input  logic [rpbu_pkg::CsrDataBits-1:0]    csr_data
);

   // Configuration registers.
   logic [rpbu_pkg::DepthBits-1:0] bit_depth_ff;
   logic [rpbu_pkg::CountBits-1:0] frame_size_ff;
   logic                           full_scale_ff;

   // Input register.
   logic                          in_valid_ff;
   logic [rpbu_pkg::WordBits-1:0] in_word_ff;

   // Unpack state.
   logic [rpbu_pkg::KeepBits-1:0]  buffer_ff,  buffer_in;
   logic [rpbu_pkg::HeldBits-1:0]  held_ff,    held_in;
   logic [rpbu_pkg::CountBits-1:0] counter_ff, counter_in;

   // Result queue.
   rpbu_pkg::result_type                  queue_ff [rpbu_pkg::QueueDepth];
   logic [rpbu_pkg::QueueIdxBits-1:0]     head_ff, head_in;
   logic [rpbu_pkg::QueueCntBits-1:0]     fill_ff, fill_in;

   logic                                  pop, process;
   logic [rpbu_pkg::QueueCntBits-1:0]     fill_after_pop;
   logic [rpbu_pkg::QueueIdxBits-1:0]     tail0, tail1;

   logic [rpbu_pkg::DepthBits-1:0]  depth;
   logic [rpbu_pkg::WordBits-1:0]   pix_mask;
   logic [rpbu_pkg::JoinBits-1:0]   joined;
   logic [rpbu_pkg::TotalBits-1:0]  total, total1, total2;
   logic                            emit1, emit2, last1, last2;
   logic [rpbu_pkg::WordBits-1:0]   raw1, raw2;
   logic [rpbu_pkg::CountBits-1:0]  count1, count2;
   logic [rpbu_pkg::TotalBits-1:0]  held_next;
   rpbu_pkg::result_type            res1, res2;

   assign csr_ready = 1'b1;

   assign rsp_valid       = (fill_ff != '0);
   assign rsp_pixel_value = queue_ff[head_ff].pixel_value;
   assign rsp_frame_end   = queue_ff[head_ff].frame_end;

   assign pop            = rsp_valid & ~rsp_stall;
   assign fill_after_pop = fill_ff - {{(rpbu_pkg::QueueCntBits-1){1'b0}}, pop};
   // A word may yield two pixels, so it leaves the input register only when
   // two queue entries are free.
   assign process   = in_valid_ff & (fill_after_pop <= rpbu_pkg::QueueCntBits'(2));
   assign req_stall = in_valid_ff & ~process;

   assign tail0 = head_ff + fill_after_pop[rpbu_pkg::QueueIdxBits-1:0] +
                  rpbu_pkg::QueueIdxBits'(pop);
   assign tail1 = tail0 + rpbu_pkg::QueueIdxBits'(1);

   function automatic logic [rpbu_pkg::WordBits-1:0] justify(
      input logic [rpbu_pkg::WordBits-1:0]  raw,
      input logic [rpbu_pkg::DepthBits-1:0] d,
      input logic                           full_scale
   );
      logic [rpbu_pkg::DepthBits-1:0] sh;
      sh = rpbu_pkg::DepthBits'(rpbu_pkg::WordBits) - d;
      return full_scale ? raw : (raw << sh);
   endfunction

   always_comb begin
      // Out-of-range depths are clamped to the supported span.
      if (bit_depth_ff < rpbu_pkg::DepthBits'(rpbu_pkg::MinBitDepth)) begin
         depth = rpbu_pkg::DepthBits'(rpbu_pkg::MinBitDepth);
      end else if (bit_depth_ff > rpbu_pkg::DepthBits'(rpbu_pkg::MaxBitDepth)) begin
         depth = rpbu_pkg::DepthBits'(rpbu_pkg::MaxBitDepth);
      end else begin
         depth = bit_depth_ff;
      end
      pix_mask = ~({rpbu_pkg::WordBits{1'b1}} << depth);

      joined = {buffer_ff, in_word_ff};
      total  = {1'b0, held_ff} + rpbu_pkg::TotalBits'(rpbu_pkg::WordBits);

      emit1  = (total >= depth);
      total1 = total - depth;
      raw1   = rpbu_pkg::WordBits'(joined >> total1) & pix_mask;
      count1 = counter_ff + rpbu_pkg::CountBits'(1);
      last1  = (count1 == frame_size_ff);

      emit2  = emit1 & ~last1 & (total1 >= depth);
      total2 = total1 - depth;
      raw2   = rpbu_pkg::WordBits'(joined >> total2) & pix_mask;
      count2 = counter_ff + rpbu_pkg::CountBits'(2);
      last2  = (count2 == frame_size_ff);

      res1.pixel_value = justify(raw1, depth, full_scale_ff);
      res1.frame_end   = last1;
      res2.pixel_value = justify(raw2, depth, full_scale_ff);
      res2.frame_end   = last2;

      // The frame end drops the rest of the word and restarts the count.
      if (emit1 && last1) begin
         held_next  = '0;
         counter_in = '0;
      end else if (emit2 && last2) begin
         held_next  = '0;
         counter_in = '0;
      end else if (emit2) begin
         held_next  = total2;
         counter_in = count2;
      end else if (emit1) begin
         held_next  = total1;
         counter_in = count1;
      end else begin
         held_next  = total;
         counter_in = counter_ff;
      end
      held_in   = held_next[rpbu_pkg::HeldBits-1:0];
      buffer_in = joined[rpbu_pkg::KeepBits-1:0] &
                  ~({rpbu_pkg::KeepBits{1'b1}} << held_in);

      if (!process) begin
         held_in    = held_ff;
         buffer_in  = buffer_ff;
         counter_in = counter_ff;
      end

      head_in = head_ff + rpbu_pkg::QueueIdxBits'(pop);
      fill_in = fill_after_pop;
      if (process) begin
         fill_in = fill_after_pop + rpbu_pkg::QueueCntBits'(emit1) +
                   rpbu_pkg::QueueCntBits'(emit2);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_depth_ff  <= rpbu_pkg::BitDepthReset;
         frame_size_ff <= rpbu_pkg::PixelsPerFrameReset;
         full_scale_ff <= 1'b0;
         in_valid_ff   <= 1'b0;
         buffer_ff     <= '0;
         held_ff       <= '0;
         counter_ff    <= '0;
         head_ff       <= '0;
         fill_ff       <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               rpbu_pkg::RegBitDepth: begin
                  bit_depth_ff <= csr_data[rpbu_pkg::DepthBits-1:0];
               end
               rpbu_pkg::RegPixelsPerFrame: begin
                  frame_size_ff <= csr_data[rpbu_pkg::CountBits-1:0];
               end
               rpbu_pkg::RegFullScaleMode: begin
                  full_scale_ff <= csr_data[0];
               end
               default: begin
               end
            endcase
         end
         if (req_valid && !req_stall) begin
            in_valid_ff <= 1'b1;
         end else if (process) begin
            in_valid_ff <= 1'b0;
         end
         buffer_ff  <= buffer_in;
         held_ff    <= held_in;
         counter_ff <= counter_in;
         head_ff    <= head_in;
         fill_ff    <= fill_in;
      end
   end

   // Payload registers: no reset needed.
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_word_ff <= req_packed_word;
      end
      if (process && emit1) begin
         queue_ff[tail0] <= res1;
      end
      if (process && emit2) begin
         queue_ff[tail1] <= res2;
      end
   end

endmodule
